>>> rtl/sti_pkg.sv
// Shared widths, types and helpers for the segment/triangle intersection pipeline.
package sti_pkg;

    localparam int COORD_BITS = 21;
    localparam int POINT_W    = 63;
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int PROD_W     = 2 * DIFF_W;
    localparam int CROSS_W    = PROD_W + 1;
    localparam int LO_W       = CROSS_W / 2;
    localparam int HI_W       = CROSS_W - LO_W;
    localparam int PH_W       = DIFF_W + HI_W;
    localparam int PL_W       = DIFF_W + LO_W + 1;
    localparam int TERM_W     = DIFF_W + CROSS_W;
    localparam int DOT_W      = TERM_W + 2;
    localparam int SLACK_W    = 16;
    localparam int TOL_W      = 62;
    localparam int NCHUNK     = 3;
    localparam int CHUNK_W    = (DOT_W + NCHUNK - 1) / NCHUNK;
    localparam int SPROD_W    = CHUNK_W + SLACK_W;
    localparam int SD_W       = NCHUNK * CHUNK_W + SLACK_W;
    localparam int CMP_W      = DOT_W + SLACK_W + 2;

    localparam int S_TDATA_W  = 320;
    localparam int M_TDATA_W  = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = TOL_W;

    // Front 3 + dot 3 + classify 5 register stages.
    localparam int PIPE_DEPTH = 11;
    localparam int RUN_W      = $clog2(PIPE_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_DET_TOL    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_BARY_SLACK = CFG_IDX_W'(1);

    typedef enum logic [2:0] {
        RSN_HIT      = 3'd0,
        RSN_PARALLEL = 3'd1,
        RSN_U_OUT    = 3'd2,
        RSN_V_OUT    = 3'd3,
        RSN_T_OUT    = 3'd4
    } t_reason;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [DIFF_W-1:0]     t_diff;
    typedef logic signed [CROSS_W-1:0]    t_cross;
    typedef logic signed [DOT_W-1:0]      t_dot;

    typedef t_coord [2:0] t_pvec;
    typedef t_diff  [2:0] t_dvec;
    typedef t_cross [2:0] t_cvec;

    // Edge vectors and cross products handed from the front end to the dot stage.
    typedef struct packed {
        t_dvec d;
        t_dvec e1;
        t_dvec e2;
        t_dvec w;
        t_cvec p;
        t_cvec q;
    } t_geo;

    // Determinant and the u, v, t numerators.
    typedef struct packed {
        t_dot det;
        t_dot u;
        t_dot v;
        t_dot t;
    } t_dots;

    function automatic t_pvec unpack_point(input logic [POINT_W-1:0] pt);
        t_pvec r;
        for (int k = 0; k < 3; k++) begin
            r[k] = pt[k*COORD_BITS +: COORD_BITS];
        end
        return r;
    endfunction

endpackage

>>> rtl/segment_triangle_intersect_top.sv
// Top level: stream ports, configuration registers, pipeline and checks.
// Segment/triangle intersection test, one word per clock. Each input word is
// a segment and a triangle; each output word gives a hit flag and the reason
// for a miss. The pipeline is 11 register stages deep; it takes a new word
// every cycle, and the whole pipeline holds when the output word is not taken.
// The depth is set by the split 22x45-bit dot-product multipliers, the
// slack-times-determinant products and the 87-bit bound compares, each
// given its own stages. The user must write configuration through the cfg
// channel while no words are in flight; the block itself does not enforce
// this. The cfg channel is always ready.
module segment_triangle_intersect_top
    import sti_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // seg_start[62:0], seg_end[125:63], vertex_a[188:126],
    // vertex_b[251:189], vertex_c[314:252], zero fill above
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // hit[0], miss_reason[3:1], zero fill above
    output logic [M_TDATA_W-1:0]  m_axis_tdata,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [TOL_W-1:0]   r_det_tol;
    logic [SLACK_W-1:0] r_slack;
    logic [RUN_W-1:0]   r_run;

    logic    w_en;
    logic    front_vld, dot_vld;
    t_geo    front_geo;
    t_dots   dot_out;
    logic    cls_hit;
    t_reason cls_reason;

    // advance everything unless the output word is stuck
    assign w_en          = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = w_en;
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_det_tol <= '0;
            r_slack   <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_DET_TOL:    r_det_tol <= i_cfg_data[TOL_W-1:0];
                CFG_BARY_SLACK: r_slack   <= i_cfg_data[SLACK_W-1:0];
                default:        ;
            endcase
        end
    end

    sti_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_en),
        .i_valid     (s_axis_tvalid),
        .i_seg_start (s_axis_tdata[0*POINT_W +: POINT_W]),
        .i_seg_end   (s_axis_tdata[1*POINT_W +: POINT_W]),
        .i_vertex_a  (s_axis_tdata[2*POINT_W +: POINT_W]),
        .i_vertex_b  (s_axis_tdata[3*POINT_W +: POINT_W]),
        .i_vertex_c  (s_axis_tdata[4*POINT_W +: POINT_W]),
        .o_valid     (front_vld),
        .o_geo       (front_geo)
    );

    sti_dot u_dot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (front_vld),
        .i_geo   (front_geo),
        .o_valid (dot_vld),
        .o_dots  (dot_out)
    );

    sti_class u_class (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_valid   (dot_vld),
        .i_dots    (dot_out),
        .i_det_tol (r_det_tol),
        .i_slack   (r_slack),
        .o_valid   (m_axis_tvalid),
        .o_hit     (cls_hit),
        .o_reason  (cls_reason)
    );

    assign m_axis_tdata = {(M_TDATA_W-4)'(0), cls_reason, cls_hit};

    // count consecutive advancing cycles, saturating at the pipeline depth
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= '0;
        end else if (!w_en) begin
            r_run <= '0;
        end else if (r_run != RUN_W'(PIPE_DEPTH)) begin
            r_run <= r_run + RUN_W'(1);
        end
    end

    // a word that flowed through without a stall shows up exactly at the end
    a_latency : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_run == RUN_W'(PIPE_DEPTH)) |-> (m_axis_tvalid == $past(s_axis_tvalid, PIPE_DEPTH)))
        else $error("output valid does not match input valid at pipeline depth");

    a_hit_code : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[0] == (m_axis_tdata[3:1] == RSN_HIT)))
        else $error("hit flag disagrees with miss reason");

endmodule

>>> rtl/sti_front.sv
// Front end: unpack points, form edge vectors, then the two cross products.
module sti_front
    import sti_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic [POINT_W-1:0] i_seg_start,
    input  logic [POINT_W-1:0] i_seg_end,
    input  logic [POINT_W-1:0] i_vertex_a,
    input  logic [POINT_W-1:0] i_vertex_b,
    input  logic [POINT_W-1:0] i_vertex_c,
    output logic               o_valid,
    output t_geo               o_geo
);

    logic [2:0] r_vld;

    t_pvec s_pt, e_pt, a_pt, b_pt, c_pt;
    t_dvec n_a_d, n_a_e1, n_a_e2, n_a_w;
    t_dvec r_a_d, r_a_e1, r_a_e2, r_a_w;

    logic signed [PROD_W-1:0] n_b_pp [0:2];
    logic signed [PROD_W-1:0] n_b_pm [0:2];
    logic signed [PROD_W-1:0] n_b_qp [0:2];
    logic signed [PROD_W-1:0] n_b_qm [0:2];
    logic signed [PROD_W-1:0] r_b_pp [0:2];
    logic signed [PROD_W-1:0] r_b_pm [0:2];
    logic signed [PROD_W-1:0] r_b_qp [0:2];
    logic signed [PROD_W-1:0] r_b_qm [0:2];
    t_dvec r_b_d, r_b_e1, r_b_e2, r_b_w;

    t_geo n_c_geo, r_c_geo;

    // stage A: differences
    always_comb begin
        s_pt = unpack_point(i_seg_start);
        e_pt = unpack_point(i_seg_end);
        a_pt = unpack_point(i_vertex_a);
        b_pt = unpack_point(i_vertex_b);
        c_pt = unpack_point(i_vertex_c);
        for (int k = 0; k < 3; k++) begin
            n_a_d[k]  = DIFF_W'($signed(e_pt[k])) - DIFF_W'($signed(s_pt[k]));
            n_a_e1[k] = DIFF_W'($signed(b_pt[k])) - DIFF_W'($signed(a_pt[k]));
            n_a_e2[k] = DIFF_W'($signed(c_pt[k])) - DIFF_W'($signed(a_pt[k]));
            n_a_w[k]  = DIFF_W'($signed(s_pt[k])) - DIFF_W'($signed(a_pt[k]));
        end
    end

    // stage B: cross-product terms, p = d x e2 and q = w x e1
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_b_pp[k] = $signed(r_a_d[(k+1)%3]) * $signed(r_a_e2[(k+2)%3]);
            n_b_pm[k] = $signed(r_a_d[(k+2)%3]) * $signed(r_a_e2[(k+1)%3]);
            n_b_qp[k] = $signed(r_a_w[(k+1)%3]) * $signed(r_a_e1[(k+2)%3]);
            n_b_qm[k] = $signed(r_a_w[(k+2)%3]) * $signed(r_a_e1[(k+1)%3]);
        end
    end

    // stage C: finish the cross products
    always_comb begin
        n_c_geo.d  = r_b_d;
        n_c_geo.e1 = r_b_e1;
        n_c_geo.e2 = r_b_e2;
        n_c_geo.w  = r_b_w;
        for (int k = 0; k < 3; k++) begin
            n_c_geo.p[k] = CROSS_W'(r_b_pp[k]) - CROSS_W'(r_b_pm[k]);
            n_c_geo.q[k] = CROSS_W'(r_b_qp[k]) - CROSS_W'(r_b_qm[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_d   <= n_a_d;
            r_a_e1  <= n_a_e1;
            r_a_e2  <= n_a_e2;
            r_a_w   <= n_a_w;
            r_b_pp  <= n_b_pp;
            r_b_pm  <= n_b_pm;
            r_b_qp  <= n_b_qp;
            r_b_qm  <= n_b_qm;
            r_b_d   <= r_a_d;
            r_b_e1  <= r_a_e1;
            r_b_e2  <= r_a_e2;
            r_b_w   <= r_a_w;
            r_c_geo <= n_c_geo;
        end
    end

    assign o_valid = r_vld[2];
    assign o_geo   = r_c_geo;

endmodule

>>> rtl/sti_dot.sv
// Dot products: determinant and the u, v, t numerators, split multiplies.
module sti_dot
    import sti_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_geo  i_geo,
    output logic  o_valid,
    output t_dots o_dots
);

    logic [2:0] r_vld;

    t_dvec opa [0:3];
    t_cvec opb [0:3];

    logic signed [PH_W-1:0]   n_d_ph   [0:3][0:2];
    logic signed [PL_W-1:0]   n_d_pl   [0:3][0:2];
    logic signed [PH_W-1:0]   r_d_ph   [0:3][0:2];
    logic signed [PL_W-1:0]   r_d_pl   [0:3][0:2];
    logic signed [TERM_W-1:0] n_e_term [0:3][0:2];
    logic signed [TERM_W-1:0] r_e_term [0:3][0:2];
    t_dot                     n_f_sum  [0:3];
    t_dot                     r_f_sum  [0:3];

    // det = e1.p, u = w.p, v = d.q, t = e2.q
    always_comb begin
        opa[0] = i_geo.e1;  opb[0] = i_geo.p;
        opa[1] = i_geo.w;   opb[1] = i_geo.p;
        opa[2] = i_geo.d;   opb[2] = i_geo.q;
        opa[3] = i_geo.e2;  opb[3] = i_geo.q;
        for (int j = 0; j < 4; j++) begin
            for (int k = 0; k < 3; k++) begin
                n_d_ph[j][k] = $signed(opa[j][k]) * $signed(opb[j][k][CROSS_W-1:LO_W]);
                n_d_pl[j][k] = $signed(opa[j][k]) * $signed({1'b0, opb[j][k][LO_W-1:0]});
            end
        end
    end

    // recombine the high and low halves of each product
    always_comb begin
        for (int j = 0; j < 4; j++) begin
            for (int k = 0; k < 3; k++) begin
                n_e_term[j][k] = (TERM_W'(r_d_ph[j][k]) <<< LO_W) + TERM_W'(r_d_pl[j][k]);
            end
        end
    end

    always_comb begin
        for (int j = 0; j < 4; j++) begin
            n_f_sum[j] = DOT_W'(r_e_term[j][0]) + DOT_W'(r_e_term[j][1])
                       + DOT_W'(r_e_term[j][2]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d_ph   <= n_d_ph;
            r_d_pl   <= n_d_pl;
            r_e_term <= n_e_term;
            r_f_sum  <= n_f_sum;
        end
    end

    assign o_valid     = r_vld[2];
    assign o_dots.det  = r_f_sum[0];
    assign o_dots.u    = r_f_sum[1];
    assign o_dots.v    = r_f_sum[2];
    assign o_dots.t    = r_f_sum[3];

endmodule

>>> rtl/sti_class.sv
// Classification: sign fix, parallel test, slack bounds, range compares, reason.
module sti_class
    import sti_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  t_dots              i_dots,
    input  logic [TOL_W-1:0]   i_det_tol,
    input  logic [SLACK_W-1:0] i_slack,
    output logic               o_valid,
    output logic               o_hit,
    output t_reason            o_reason
);

    logic [4:0] r_vld;

    // stage G
    logic                    n_g_flip, r_g_flip;
    logic [DOT_W-1:0]        n_g_dmag, r_g_dmag;
    t_dot                    n_g_u, n_g_v, n_g_t, r_g_u, r_g_v, r_g_t;
    logic signed [DOT_W:0]   n_g_uvraw, r_g_uvraw;
    logic                    n_g_par, r_g_par;

    // stage H
    logic [NCHUNK*CHUNK_W-1:0] dpad;
    logic [SPROD_W-1:0]        n_h_sp [0:NCHUNK-1];
    logic [SPROD_W-1:0]        r_h_sp [0:NCHUNK-1];
    logic signed [DOT_W:0]     n_h_uv, r_h_uv;
    logic [DOT_W-1:0]          r_h_dmag;
    t_dot                      r_h_u, r_h_v, r_h_t;
    logic                      r_h_par;

    // stage I
    logic [SD_W-1:0]           n_i_sd, r_i_sd;
    logic [DOT_W-1:0]          r_i_dmag;
    t_dot                      r_i_u, r_i_v, r_i_t;
    logic signed [DOT_W:0]     r_i_uv;
    logic                      r_i_par;

    // stage J
    logic signed [CMP_W-1:0]   n_j_hb, n_j_lb, n_j_xu, n_j_xv, n_j_xt, n_j_xuv;
    logic signed [CMP_W-1:0]   r_j_hb, r_j_lb, r_j_xu, r_j_xv, r_j_xt, r_j_xuv;
    logic                      r_j_par;

    // stage K
    logic                      u_out, v_out, t_out;
    t_reason                   n_k_reason, r_k_reason;
    logic                      r_k_hit;

    // make the determinant positive, flipping the numerators with it
    always_comb begin
        n_g_flip  = i_dots.det[DOT_W-1];
        n_g_dmag  = n_g_flip ? -i_dots.det : i_dots.det;
        n_g_u     = n_g_flip ? -i_dots.u : i_dots.u;
        n_g_v     = n_g_flip ? -i_dots.v : i_dots.v;
        n_g_t     = n_g_flip ? -i_dots.t : i_dots.t;
        n_g_uvraw = (DOT_W+1)'(i_dots.u) + (DOT_W+1)'(i_dots.v);
        n_g_par   = (n_g_dmag <= DOT_W'(i_det_tol));
    end

    // slack times |det| in chunk products
    always_comb begin
        dpad   = (NCHUNK*CHUNK_W)'(r_g_dmag);
        n_h_uv = r_g_flip ? -r_g_uvraw : r_g_uvraw;
        for (int c = 0; c < NCHUNK; c++) begin
            n_h_sp[c] = dpad[c*CHUNK_W +: CHUNK_W] * i_slack;
        end
    end

    always_comb begin
        n_i_sd = '0;
        for (int c = 0; c < NCHUNK; c++) begin
            n_i_sd = n_i_sd + (SD_W'(r_h_sp[c]) << (c*CHUNK_W));
        end
    end

    // bounds: low = -slack*D, high = (1 + slack)*D, numerators scaled by 2^16
    always_comb begin
        n_j_hb  = (CMP_W'(r_i_dmag) << SLACK_W) + CMP_W'(r_i_sd);
        n_j_lb  = -CMP_W'(r_i_sd);
        n_j_xu  = CMP_W'(r_i_u) <<< SLACK_W;
        n_j_xv  = CMP_W'(r_i_v) <<< SLACK_W;
        n_j_xt  = CMP_W'(r_i_t) <<< SLACK_W;
        n_j_xuv = CMP_W'(r_i_uv) <<< SLACK_W;
    end

    // first failing check decides the reason
    always_comb begin
        u_out = (r_j_xu < r_j_lb) || (r_j_xu > r_j_hb);
        v_out = (r_j_xv < r_j_lb) || (r_j_xuv > r_j_hb);
        t_out = (r_j_xt < r_j_lb) || (r_j_xt > r_j_hb);
        if (r_j_par) begin
            n_k_reason = RSN_PARALLEL;
        end else if (u_out) begin
            n_k_reason = RSN_U_OUT;
        end else if (v_out) begin
            n_k_reason = RSN_V_OUT;
        end else if (t_out) begin
            n_k_reason = RSN_T_OUT;
        end else begin
            n_k_reason = RSN_HIT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[3:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_g_flip   <= n_g_flip;
            r_g_dmag   <= n_g_dmag;
            r_g_u      <= n_g_u;
            r_g_v      <= n_g_v;
            r_g_t      <= n_g_t;
            r_g_uvraw  <= n_g_uvraw;
            r_g_par    <= n_g_par;

            r_h_sp     <= n_h_sp;
            r_h_uv     <= n_h_uv;
            r_h_dmag   <= r_g_dmag;
            r_h_u      <= r_g_u;
            r_h_v      <= r_g_v;
            r_h_t      <= r_g_t;
            r_h_par    <= r_g_par;

            r_i_sd     <= n_i_sd;
            r_i_dmag   <= r_h_dmag;
            r_i_u      <= r_h_u;
            r_i_v      <= r_h_v;
            r_i_t      <= r_h_t;
            r_i_uv     <= r_h_uv;
            r_i_par    <= r_h_par;

            r_j_hb     <= n_j_hb;
            r_j_lb     <= n_j_lb;
            r_j_xu     <= n_j_xu;
            r_j_xv     <= n_j_xv;
            r_j_xt     <= n_j_xt;
            r_j_xuv    <= n_j_xuv;
            r_j_par    <= r_i_par;

            r_k_reason <= n_k_reason;
            r_k_hit    <= (n_k_reason == RSN_HIT);
        end
    end

    assign o_valid  = r_vld[4];
    assign o_hit    = r_k_hit;
    assign o_reason = r_k_reason;

endmodule

>>> dv/segment_triangle_intersect_top_tb.sv
// Self-checking testbench for the segment/triangle intersection pipeline.
module segment_triangle_intersect_top_tb;
    import sti_pkg::*;

    typedef logic signed [127:0]  s128;
    typedef logic [S_TDATA_W-1:0] query_t;
    typedef logic [POINT_W-1:0]   point_t;

    typedef struct packed {
        logic    hit;
        t_reason reason;
    } verdict_t;

    localparam int MAX_C = (1 << (COORD_BITS - 1)) - 1;
    localparam int MIN_C = -(1 << (COORD_BITS - 1));
    localparam int UNIT  = 1024;  // 1.0 in Q10.10
    localparam logic [TOL_W-1:0] TOL_MAX = '1;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // Local copies of the block's registers, as the predictor sees them.
    logic [TOL_W-1:0]   cfg_tol;
    logic [SLACK_W-1:0] cfg_slack;

    verdict_t expected_verdicts[$];
    int       mismatch_count;
    logic     steady;
    logic     stall_req;
    int       stall_left;

    segment_triangle_intersect_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Moller-Trumbore classification with exact 128-bit integer products.
    function automatic t_reason classify_query(input query_t w);
        s128    pt[5][3];
        s128    d[3], e1[3], e2[3], wv[3], p[3], q[3];
        s128    det, nu, nv, nt, lo_b, hi_b;
        t_coord c;
        logic   flip;
        for (int k = 0; k < 5; k++) begin
            for (int i = 0; i < 3; i++) begin
                c = w[k*POINT_W + i*COORD_BITS +: COORD_BITS];
                pt[k][i] = c;
            end
        end
        for (int i = 0; i < 3; i++) begin
            d[i]  = pt[1][i] - pt[0][i];
            e1[i] = pt[3][i] - pt[2][i];
            e2[i] = pt[4][i] - pt[2][i];
            wv[i] = pt[0][i] - pt[2][i];
        end
        p[0] = d[1] * e2[2] - d[2] * e2[1];
        p[1] = d[2] * e2[0] - d[0] * e2[2];
        p[2] = d[0] * e2[1] - d[1] * e2[0];
        q[0] = wv[1] * e1[2] - wv[2] * e1[1];
        q[1] = wv[2] * e1[0] - wv[0] * e1[2];
        q[2] = wv[0] * e1[1] - wv[1] * e1[0];
        det  = e1[0] * p[0] + e1[1] * p[1] + e1[2] * p[2];
        flip = det < 0;
        if (flip) det = -det;
        if (det <= s128'(cfg_tol)) return RSN_PARALLEL;
        nu = wv[0] * p[0] + wv[1] * p[1] + wv[2] * p[2];
        nv = d[0] * q[0] + d[1] * q[1] + d[2] * q[2];
        nt = e2[0] * q[0] + e2[1] * q[1] + e2[2] * q[2];
        if (flip) begin
            nu = -nu;
            nv = -nv;
            nt = -nt;
        end
        // Bounds scaled by 2^16 so the slack fraction stays exact.
        lo_b = -(det * s128'(cfg_slack));
        hi_b = det * (s128'(cfg_slack) + 65536);
        if ((nu <<< 16) < lo_b || (nu <<< 16) > hi_b) return RSN_U_OUT;
        if ((nv <<< 16) < lo_b || ((nu + nv) <<< 16) > hi_b) return RSN_V_OUT;
        if ((nt <<< 16) < lo_b || (nt <<< 16) > hi_b) return RSN_T_OUT;
        return RSN_HIT;
    endfunction

    function automatic point_t pack_pt(input int x, input int y, input int z);
        return {COORD_BITS'(z), COORD_BITS'(y), COORD_BITS'(x)};
    endfunction

    function automatic query_t pack_item(input point_t s, e, a, b, c);
        return query_t'({c, b, a, e, s});
    endfunction

    function automatic int spread(input int r);
        return int'($urandom_range(0, 2 * r)) - r;
    endfunction

    function automatic int extreme_coord();
        case ($urandom_range(0, 3))
            0: return MAX_C;
            1: return MIN_C;
            2: return 0;
            default: return -1;
        endcase
    endfunction

    // Barycentric weight out of 256, biased toward the triangle edges.
    function automatic int bary_weight();
        case ($urandom_range(0, 9))
            0: return 0;
            1: return 256;
            default: return int'($urandom_range(0, 336)) - 40;
        endcase
    endfunction

    function automatic point_t extreme_pt();
        return pack_pt(extreme_coord(), extreme_coord(), extreme_coord());
    endfunction

    function automatic point_t raw_pt();
        return POINT_W'({$urandom, $urandom});
    endfunction

    // Mostly segments aimed near a random triangle; the rest noise and flat cases.
    function automatic query_t random_query();
        int a[3], b[3], c[3], s[3], e[3], off[3], pnt[3];
        int kind, r, ui, vi, m, k1, k2, tmp;
        logic cross_plane;
        kind = $urandom_range(0, 99);
        if (kind < 10)
            return pack_item(raw_pt(), raw_pt(), raw_pt(), raw_pt(), raw_pt());
        if (kind < 20)
            return pack_item(extreme_pt(), extreme_pt(), extreme_pt(), extreme_pt(),
                             extreme_pt());
        r = (kind < 28) ? (1 << $urandom_range(2, 15)) : (1 << $urandom_range(2, 17));
        for (int i = 0; i < 3; i++) begin
            a[i]   = spread(r);
            b[i]   = spread(r);
            c[i]   = spread(r);
            off[i] = spread(r);
        end
        if (kind < 28) begin
            k1 = int'($urandom_range(0, 4)) - 2;
            k2 = int'($urandom_range(0, 4)) - 2;
            for (int i = 0; i < 3; i++) begin
                s[i] = spread(r);
                if (kind < 24) begin
                    // collapse the triangle onto a line
                    c[i] = a[i] + k1 * (b[i] - a[i]);
                    e[i] = spread(r);
                end else begin
                    // keep the segment parallel to the triangle plane
                    e[i] = s[i] + k1 * (b[i] - a[i]) + k2 * (c[i] - a[i]);
                end
            end
        end else begin
            ui          = bary_weight();
            vi          = bary_weight();
            cross_plane = $urandom_range(0, 9) < 7;
            m           = cross_plane ? $urandom_range(1, 8) : $urandom_range(0, 7);
            for (int i = 0; i < 3; i++) begin
                pnt[i] = a[i] + ((b[i] - a[i]) * ui + (c[i] - a[i]) * vi) / 256;
                s[i]   = pnt[i] + off[i];
                e[i]   = cross_plane ? pnt[i] - off[i] * m / 4 : pnt[i] + off[i] * m / 8;
            end
            if ($urandom_range(0, 1)) begin
                for (int i = 0; i < 3; i++) begin
                    tmp  = s[i];
                    s[i] = e[i];
                    e[i] = tmp;
                end
            end
        end
        return pack_item(pack_pt(s[0], s[1], s[2]), pack_pt(e[0], e[1], e[2]),
                         pack_pt(a[0], a[1], a[2]), pack_pt(b[0], b[1], b[2]),
                         pack_pt(c[0], c[1], c[2]));
    endfunction

    // Offer one word, idling first at random; valid stays high for the next caller.
    task automatic send_item(input query_t word);
        verdict_t v;
        while (!steady && $urandom_range(0, 99) < 23) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        do @(posedge i_clk); while (!s_axis_tready);
        v.reason = classify_query(word);
        v.hit    = (v.reason == RSN_HIT);
        expected_verdicts.insert(expected_verdicts.size(), v);
    endtask

    task automatic run_random(input int count);
        repeat (count) send_item(random_query());
    endtask

    // Vertical segment through (x, y) against the unit triangle in the z = 0 plane.
    task automatic send_vertical(input int x, input int y, input int z0, input int z1);
        send_item(pack_item(pack_pt(x, y, z0), pack_pt(x, y, z1), pack_pt(0, 0, 0),
                            pack_pt(UNIT, 0, 0), pack_pt(0, UNIT, 0)));
    endtask

    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        while (expected_verdicts.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_DET_TOL) cfg_tol = value;
        else cfg_slack = value[SLACK_W-1:0];
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apply_settings(input logic [TOL_W-1:0] tol,
                                  input logic [SLACK_W-1:0] slack);
        wait_for_results();
        write_reg(CFG_DET_TOL, tol);
        write_reg(CFG_BARY_SLACK, slack);
    endtask

    // Runs on the reset register values.
    task automatic test_reset_defaults_and_extremes();
        send_vertical(256, 256, 512, -512);
        send_vertical(-10, 100, 512, -512);
        send_vertical(100, -10, 512, -512);
        send_vertical(600, 600, 512, -512);
        send_vertical(1100, 0, 512, -512);
        send_vertical(UNIT, 0, 512, -512);
        send_vertical(0, UNIT, 512, -512);
        send_vertical(512, 512, 512, -512);
        send_vertical(200, 200, 1024, 512);
        send_vertical(200, 200, -512, -1024);
        send_vertical(200, 200, 512, 0);
        send_vertical(200, 200, 0, -512);
        // reversed direction flips the determinant sign
        send_vertical(200, 200, -512, 512);
        send_vertical(-10, 100, -512, 512);
        // segment lying in a plane parallel to the triangle
        send_item(pack_item(pack_pt(0, 0, 5), pack_pt(100, 100, 5), pack_pt(0, 0, 0),
                            pack_pt(UNIT, 0, 0), pack_pt(0, UNIT, 0)));
        // degenerate triangle with two equal vertices
        send_item(pack_item(pack_pt(10, 10, 5), pack_pt(10, 10, -5), pack_pt(0, 0, 0),
                            pack_pt(0, 0, 0), pack_pt(0, UNIT, 0)));
        send_item('0);
        send_item(query_t'({5{{POINT_W{1'b1}}}}));
        send_item(pack_item(pack_pt(0, 0, MAX_C), pack_pt(0, 0, MIN_C),
                            pack_pt(MIN_C, MIN_C, 0), pack_pt(MAX_C, MIN_C, 0),
                            pack_pt(MIN_C, MAX_C, 0)));
        repeat (3) send_item(pack_item(extreme_pt(), extreme_pt(), extreme_pt(),
                                       extreme_pt(), extreme_pt()));
    endtask

    task automatic test_slack_and_tolerance_edges();
        // slack of 1/16: a weight of exactly -64/1024 still passes
        apply_settings('0, 16'd4096);
        send_vertical(-64, 100, 512, -512);
        send_vertical(-65, 100, 512, -512);
        send_vertical(100, -64, 512, -512);
        send_vertical(100, -65, 512, -512);
        send_vertical(200, 200, 1024, 64);
        send_vertical(200, 200, 1024, 60);
        // this segment has det = 2^30
        apply_settings(TOL_W'(64'd1 << 30), '0);
        send_vertical(256, 256, 512, -512);
        apply_settings(TOL_W'((64'd1 << 30) - 1), '0);
        send_vertical(256, 256, 512, -512);
    endtask

    task automatic test_settings_sweep();
        apply_settings('0, 16'hFFFF);
        run_random(170);
        apply_settings(TOL_MAX, '0);
        run_random(170);
        apply_settings(TOL_MAX, 16'hFFFF);
        run_random(170);
        apply_settings(TOL_W'(64'd1 << 40), 16'd16384);
        run_random(170);
        apply_settings(TOL_W'(1), 16'd1);
        run_random(170);
        apply_settings('0, '0);
        run_random(170);
    endtask

    task automatic test_steady_stream();
        steady <= 1'b1;
        run_random(200);
        steady <= 1'b0;
    endtask

    // Receiver holds off while words keep coming, so the pipeline backs up.
    task automatic test_output_stall();
        stall_req <= 1'b1;
        run_random(80);
    endtask

    task automatic test_drain_pause();
        run_random(30);
        wait_for_results();
        run_random(30);
    endtask

    always @(posedge i_clk) begin
        if (stall_req) begin
            stall_left = 150;
            stall_req <= 1'b0;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else if (steady) begin
            m_axis_tready <= 1'b1;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= 23);
        end
    end

    always @(posedge i_clk) begin
        verdict_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_verdicts.size() == 0) begin
                $display("%0t: unexpected result word, expected none, actual %h",
                         $time, m_axis_tdata);
                mismatch_count++;
            end else begin
                want = expected_verdicts.pop_front();
                if (m_axis_tdata[0] !== want.hit) begin
                    $display("%0t: hit mismatch, expected %0b actual %0b",
                             $time, want.hit, m_axis_tdata[0]);
                    mismatch_count++;
                end
                if (m_axis_tdata[3:1] !== want.reason) begin
                    $display("%0t: miss_reason mismatch, expected %0d actual %0d",
                             $time, want.reason, m_axis_tdata[3:1]);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("segment_triangle_intersect_top test failed");
        $finish;
    end

    initial begin
        i_rst_n        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        m_axis_tready  = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = '0;
        i_cfg_data     = '0;
        cfg_tol        = '0;
        cfg_slack      = '0;
        mismatch_count = 0;
        steady         = 1'b0;
        stall_req      = 1'b0;
        stall_left     = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults_and_extremes();
        test_slack_and_tolerance_edges();
        test_settings_sweep();
        test_steady_stream();
        test_output_stall();
        test_drain_pause();

        wait_for_results();
        repeat (PIPE_DEPTH + 4) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("segment_triangle_intersect_top test passed");
        end else begin
            $display("segment_triangle_intersect_top test failed");
        end
        $finish;
    end

endmodule
